// ===== src/slfc_pkg.sv =====
package slfc_pkg;

  typedef enum logic [1:0] {
    OP_RX_BYTE   = 2'd0,
    OP_SEND      = 2'd1,
    OP_INIT      = 2'd2,
    OP_TIMEOUT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_LINK_BYTE = 2'd0,
    KIND_FRAME     = 2'd1,
    KIND_ECHO_OK   = 2'd2,
    KIND_INIT_FAIL = 2'd3
  } kind_t;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FRAME_W = 11;
  localparam int unsigned CMD_W   = 6;

  localparam logic [7:0] ACK_BYTE    = 8'h0D;
  localparam logic [7:0] MASK_CTRL   = 8'hC0;
  localparam logic [7:0] BIT_HIGH    = 8'h20;
  localparam logic [7:0] MASK_HI_7   = 8'h1E;
  localparam logic [7:0] MASK_HI_6   = 8'h1F;
  localparam logic [7:0] MASK_LO_7   = 8'h7F;
  localparam logic [7:0] MASK_LO_6   = 8'h3F;
  localparam logic [7:0] BIT_LOW     = 8'h80;

  typedef struct packed {
    kind_t                kind;
    logic [BYTE_W-1:0]    data_byte;
    logic [FRAME_W-1:0]   frame;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    high_byte;
    logic                 awaiting;
    logic [CMD_W-1:0]     pend_low;
  } codec_state_t;

endpackage

// ===== src/serial_loop_frame_codec.sv =====
// Channel   Handshake            Payload
// -------   ------------------   ---------------------------------------------
// in        in_valid / in_ready  in_operation, in_link_byte, in_frame_word
// out       out_valid/out_ready  out_result_kind, out_out_byte, out_out_frame,
//                                out_is_last
//
// An item is decoded in the cycle it is accepted and its results land in a
// two-entry result queue; the first result is visible in the next cycle.
// An item that gives one result, or none, can follow every cycle while the
// output takes results; an item that sends a high and a low byte holds
// in_ready low until the high byte has been taken from the queue.
// Reset (synchronous, rst_n low) clears the stored high byte, the echo wait
// and the queue. A stalled output keeps in_ready low once the queue cannot
// take a worst-case pair of results.
module serial_loop_frame_codec (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_operation,
  input  logic [slfc_pkg::BYTE_W-1:0]       in_link_byte,
  input  logic [slfc_pkg::FRAME_W-1:0]      in_frame_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_result_kind,
  output logic [slfc_pkg::BYTE_W-1:0]       out_out_byte,
  output logic [slfc_pkg::FRAME_W-1:0]      out_out_frame,
  output logic                              out_is_last
);

  // Codec state: last high byte seen or sent, and the init echo wait.
  slfc_pkg::codec_state_t state_r, state_nxt;

  // Result queue; entry 0 is the head shown on the output ports.
  slfc_pkg::result_t q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]        count_r, count_nxt;

  slfc_pkg::result_t res0, res1;
  logic [1:0]        num_res;
  logic              in_acc, out_acc;

  slfc_step u_step (
    .operation  (slfc_pkg::op_t'(in_operation)),
    .link_byte  (in_link_byte),
    .frame_word (in_frame_word),
    .state_cur  (state_r),
    .state_nxt  (state_nxt),
    .num_res    (num_res),
    .res0       (res0),
    .res1       (res1)
  );

  assign out_valid = (count_r != 2'd0);
  assign out_acc   = out_valid && out_ready;
  // Accept only if the queue will be empty after this cycle's pop, so that
  // room for two results is always there.
  assign in_ready  = (count_r == 2'd0) || ((count_r == 2'd1) && out_ready);
  assign in_acc    = in_valid && in_ready;

  assign out_result_kind = q0_r.kind;
  assign out_out_byte    = q0_r.data_byte;
  assign out_out_frame   = q0_r.frame;
  assign out_is_last     = q0_r.last;

  always_comb begin
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    count_nxt = count_r;
    if (in_acc) begin
      // The queue is empty after the pop, so the new results fill from the head.
      q0_nxt    = res0;
      q1_nxt    = res1;
      count_nxt = num_res;
    end else if (out_acc) begin
      q0_nxt    = q1_r;
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      count_r <= 2'd0;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  // The queue never holds more than two results.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue overfilled");

  // With two results queued the head is the high byte of a pair.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) |-> (!q0_r.last && q1_r.last))
    else $error("result pair out of order");

  // An accepted init command always leaves the block waiting for its echo.
  a_init_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_operation == slfc_pkg::OP_INIT)) |=> state_r.awaiting)
    else $error("init did not start echo wait");

  // A result that ends an item is never followed in the queue by another.
  a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_is_last && !in_acc) |=> (count_r == 2'd0))
    else $error("result queued after last result");

endmodule

// ===== src/slfc_step.sv =====
// Combinational decode of one item against the current codec state.
module slfc_step (
  input  slfc_pkg::op_t                      operation,
  input  logic [slfc_pkg::BYTE_W-1:0]        link_byte,
  input  logic [slfc_pkg::FRAME_W-1:0]       frame_word,
  input  slfc_pkg::codec_state_t             state_cur,
  output slfc_pkg::codec_state_t             state_nxt,
  output logic [1:0]                         num_res,
  output slfc_pkg::result_t                  res0,
  output slfc_pkg::result_t                  res1
);

  logic [7:0] send_hi;
  logic [7:0] send_lo;
  logic [7:0] send_ref;
  logic [7:0] hi_sel;

  always_comb begin
    send_hi  = ({3'b000, frame_word[10:6]} & slfc_pkg::MASK_HI_7) | slfc_pkg::BIT_HIGH;
    send_lo  = ({1'b0, frame_word[6:0]} & slfc_pkg::MASK_LO_7) | slfc_pkg::BIT_LOW;
    // An init command compares against a cleared stored byte.
    send_ref = (operation == slfc_pkg::OP_INIT) ? 8'h00 : state_cur.high_byte;
    hi_sel   = '0;

    state_nxt = state_cur;
    num_res   = 2'd0;
    res0      = '{kind: slfc_pkg::KIND_LINK_BYTE, data_byte: '0, frame: '0, last: 1'b1};
    res1      = '{kind: slfc_pkg::KIND_LINK_BYTE, data_byte: '0, frame: '0, last: 1'b1};

    unique case (operation)
      slfc_pkg::OP_RX_BYTE: begin
        if (state_cur.awaiting) begin
          state_nxt.awaiting = 1'b0;
          num_res = 2'd1;
          res0.kind = (link_byte[5:0] == state_cur.pend_low) ?
                      slfc_pkg::KIND_ECHO_OK : slfc_pkg::KIND_INIT_FAIL;
        end else if ((link_byte & slfc_pkg::MASK_CTRL) == 8'h00) begin
          if (link_byte[5]) begin
            state_nxt.high_byte = link_byte;
            num_res = 2'd1;
            res0.data_byte = slfc_pkg::ACK_BYTE;
          end
        end else begin
          num_res   = 2'd1;
          res0.kind = slfc_pkg::KIND_FRAME;
          if (link_byte[7]) begin
            hi_sel     = state_cur.high_byte & slfc_pkg::MASK_HI_7;
            res0.frame = {hi_sel[4:0], 6'b0} | {4'b0, link_byte[6:0]};
          end else begin
            hi_sel     = state_cur.high_byte & slfc_pkg::MASK_HI_6;
            res0.frame = {hi_sel[4:0], link_byte[5:0]};
          end
        end
      end
      slfc_pkg::OP_SEND, slfc_pkg::OP_INIT: begin
        if (operation == slfc_pkg::OP_INIT) begin
          state_nxt.awaiting = 1'b1;
          state_nxt.pend_low = frame_word[5:0];
        end
        if (send_hi != send_ref) begin
          state_nxt.high_byte = send_hi;
          num_res        = 2'd2;
          res0.data_byte = send_hi;
          res0.last      = 1'b0;
          res1.data_byte = send_lo;
        end else begin
          state_nxt.high_byte = send_ref;
          num_res        = 2'd1;
          res0.data_byte = send_lo;
        end
      end
      slfc_pkg::OP_TIMEOUT: begin
        if (state_cur.awaiting) begin
          state_nxt.awaiting = 1'b0;
          num_res   = 2'd1;
          res0.kind = slfc_pkg::KIND_INIT_FAIL;
        end
      end
      default: begin
        num_res = 2'd0;
      end
    endcase
  end

endmodule
